// File: hdl/ssa_pkg.sv
// ----------------------------------------------------------------------------
// ssa_pkg: shared types and constants for the striped slot allocator
// Payload structs, operation and status codes, controller commands.
// ----------------------------------------------------------------------------
package ssa_pkg;

  localparam int SLOTS_DEF    = 4096;
  localparam int SECTIONS_DEF = 16;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_REINIT = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] context_id;
    logic [11:0] slot;
  } ssa_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] granted_slot;
    logic [12:0] slots_in_use;
    logic        has_room;
  } ssa_out_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture input item
    logic clr_step;  // clear one occupancy bit
    logic sec_step;  // look at the next section
    logic grant;     // grant hinted slot
    logic scan_step; // test one candidate slot
    logic do_free;   // apply free
    logic finish;    // build result
  } ssa_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic init_busy;  // clear pass after reset still running
    logic is_alloc;
    logic is_free;
    logic is_reinit;
    logic full_now;   // used count at capacity
    logic sec_ok;     // current section has a valid free hint
    logic sec_last;   // all sections tried
    logic scan_hit;   // candidate free, or scan exhausted
    logic rd_ok;      // occupancy read data valid
  } ssa_sts_t;

endpackage

// File: hdl/ssa_ctrl.sv
// ----------------------------------------------------------------------------
// ssa_ctrl: allocator sequencer
// Walks the clear pass, the section rotation and the hint scan.
// ----------------------------------------------------------------------------
module ssa_ctrl import ssa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  ssa_sts_t sts,
  output ssa_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_CLR   = 3'd2;
  localparam logic [2:0] S_SEC   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.is_reinit) state_nxt = S_CLR;
        else if (sts.is_alloc && !sts.full_now) state_nxt = S_SEC;
        else begin
          cmd.do_free = sts.is_free;
          state_nxt = S_FIN;
        end
      end
      // clear pass; the one after reset returns straight to idle
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = sts.init_busy ? S_IDLE : S_FIN;
      end
      S_SEC: begin
        if (sts.sec_ok) begin
          cmd.grant = 1'b1;
          state_nxt = S_SCAN;
        end else if (sts.sec_last) state_nxt = S_FIN;
        else cmd.sec_step = 1'b1;
      end
      S_SCAN: begin
        if (sts.rd_ok) begin
          cmd.scan_step = 1'b1;
          if (sts.scan_hit) state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else        state_r <= state_nxt;
  end

endmodule

// File: hdl/ssa_dpath.sv
// ----------------------------------------------------------------------------
// ssa_dpath: allocator datapath
// Occupancy memory, section tables, totals and result register.
// ----------------------------------------------------------------------------
module ssa_dpath import ssa_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int SECTIONS = SECTIONS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  ssa_in_t  in_item,
  input  logic     first_segment,
  input  ssa_cmd_t cmd,
  output ssa_sts_t sts,
  output ssa_out_t out_item
);

  localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SCW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int SPS = (SLOTS + SECTIONS - 1) / SECTIONS;
  localparam int CW  = $clog2(SPS + 1);
  localparam int TW  = $clog2(SLOTS + 1);
  localparam int HW  = $clog2(SLOTS + SECTIONS + 1);

  // occupancy memory: one bit per slot, one read and one write port
  logic occ_mem [SLOTS];
  logic          occ_rd_r;
  logic [SW-1:0] rd_addr;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  logic          wr_data;

  logic [CW-1:0] cnt_r  [SECTIONS];
  logic [HW-1:0] hint_r [SECTIONS];
  logic [TW-1:0] used_r;
  logic          rz_r;
  logic          init_r;
  ssa_in_t       item_r;
  logic [SW:0]   clr_r;
  logic [SCW-1:0] sec_r;
  logic [SCW:0]  tried_r;
  logic [SW-1:0] gslot_r;
  logic          up_r;
  logic [HW:0]   cand_r;
  logic          rd_ok_r;
  logic          granted_r;
  logic [1:0]    stat_r;
  ssa_out_t      out_r;

  logic [TW-1:0] cap;
  assign cap = rz_r ? TW'(SLOTS - 1) : TW'(SLOTS);

  // occupancy memory
  always_ff @(posedge clk) begin
    if (wr_en) occ_mem[wr_addr] <= wr_data;
    occ_rd_r <= occ_mem[rd_addr];
  end

  // scan candidate test; top bit of cand_r set means below slot zero
  logic [HW:0] low_lim;
  logic [HW:0] cand_nxt;
  logic        cand_in;
  logic        cand_free;
  logic        up_done;
  always_comb begin
    low_lim = (sec_r == '0 && rz_r) ? (HW+1)'(SECTIONS) : (HW+1)'(sec_r);
    cand_in = up_r ? (cand_r < (HW+1)'(SLOTS)) : (!cand_r[HW] && cand_r >= low_lim);
    cand_free = cand_in && !occ_rd_r;
    up_done = up_r && !cand_in;
  end

  always_comb begin
    if (up_done) cand_nxt = (HW+1)'(gslot_r) - (HW+1)'(SECTIONS);
    else if (up_r) cand_nxt = cand_r + (HW+1)'(SECTIONS);
    else cand_nxt = cand_r - (HW+1)'(SECTIONS);
  end

  // slot under test for free
  logic free_ok;
  assign free_ok = ({4'd0, item_r.slot} < 16'(SLOTS)) && occ_rd_r &&
                   !(item_r.slot == '0 && rz_r);
  logic [SCW-1:0] free_sec;
  assign free_sec = SCW'(item_r.slot % 12'(SECTIONS));

  // memory port selection
  logic [SW-1:0] free_slot;
  logic [HW-1:0] cur_hint;
  assign free_slot = in_item.slot[SW-1:0];
  assign cur_hint  = hint_r[sec_r];
  always_comb begin
    wr_en = 1'b0;
    wr_addr = clr_r[SW-1:0];
    wr_data = 1'b0;
    rd_addr = cand_r[SW-1:0];
    if (cmd.clr_step) wr_en = 1'b1;
    else if (cmd.grant) begin
      wr_en = 1'b1;
      wr_addr = cur_hint[SW-1:0];
      wr_data = 1'b1;
      rd_addr = SW'(cur_hint + HW'(SECTIONS));
    end else if (cmd.do_free) begin
      wr_en = free_ok;
      wr_addr = item_r.slot[SW-1:0];
    end else if (cmd.scan_step) rd_addr = cand_nxt[SW-1:0];
    else if (cmd.load) rd_addr = free_slot;
  end

  assign sts.clr_last  = (clr_r == (SW+1)'(SLOTS - 1));
  assign sts.init_busy = init_r;
  assign sts.is_alloc  = (item_r.operation == OP_ALLOC);
  assign sts.is_free   = (item_r.operation == OP_FREE);
  assign sts.is_reinit = (item_r.operation == OP_REINIT);
  assign sts.full_now  = (used_r >= cap);
  assign sts.sec_ok    = (cnt_r[sec_r] != '0) && (cur_hint < HW'(SLOTS));
  assign sts.sec_last  = (tried_r == (SCW+1)'(SECTIONS - 1));
  assign sts.scan_hit  = cand_free || (!up_r && !cand_in);
  assign sts.rd_ok     = rd_ok_r;
  assign out_item      = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      rz_r   <= 1'b0;
      init_r <= 1'b1;
      clr_r  <= '0;
      for (int i = 0; i < SECTIONS; i++) begin
        cnt_r[i]  <= CW'((SLOTS - i + SECTIONS - 1) / SECTIONS);
        hint_r[i] <= HW'(i);
      end
    end else begin
      rd_ok_r <= cmd.grant || cmd.scan_step;
      if (cmd.load) begin
        item_r    <= in_item;
        clr_r     <= '0;
        sec_r     <= SCW'(in_item.context_id % 16'(SECTIONS));
        tried_r   <= '0;
        granted_r <= 1'b0;
        stat_r    <= ST_DONE;
      end
      // clear pass; tables reload only for a reinitialise
      if (cmd.clr_step) begin
        clr_r <= clr_r + 1'b1;
        if (sts.clr_last) begin
          init_r <= 1'b0;
          if (!init_r) begin
            rz_r   <= first_segment;
            used_r <= '0;
            for (int i = 0; i < SECTIONS; i++) begin
              if (i == 0 && first_segment) begin
                cnt_r[i]  <= CW'((SLOTS + SECTIONS - 1) / SECTIONS - 1);
                hint_r[i] <= HW'(SECTIONS);
              end else begin
                cnt_r[i]  <= CW'((SLOTS - i + SECTIONS - 1) / SECTIONS);
                hint_r[i] <= HW'(i);
              end
            end
          end
        end
      end
      if (cmd.sec_step) begin
        sec_r   <= (sec_r == SCW'(SECTIONS - 1)) ? '0 : sec_r + 1'b1;
        tried_r <= tried_r + 1'b1;
      end
      if (cmd.grant) begin
        gslot_r   <= cur_hint[SW-1:0];
        granted_r <= 1'b1;
        used_r    <= used_r + 1'b1;
        cnt_r[sec_r] <= cnt_r[sec_r] - 1'b1;
        up_r      <= 1'b1;
        cand_r    <= (HW+1)'(cur_hint) + (HW+1)'(SECTIONS);
      end
      if (cmd.scan_step) begin
        if (cand_free) hint_r[sec_r] <= HW'(cand_r);
        if (up_done) up_r <= 1'b0;
        cand_r  <= cand_nxt;
      end
      if (cmd.do_free) begin
        if (!free_ok) stat_r <= ST_IGNORED;
        else begin
          if (used_r != '0) used_r <= used_r - 1'b1;
          cnt_r[free_sec]  <= cnt_r[free_sec] + 1'b1;
          hint_r[free_sec] <= HW'(item_r.slot);
        end
      end
      if (cmd.finish) begin
        out_r.slots_in_use <= 13'(used_r);
        out_r.has_room     <= (used_r < cap);
        if (sts.is_alloc && !granted_r) begin
          out_r.status       <= ST_FULL;
          out_r.granted_slot <= '0;
        end else begin
          out_r.status       <= stat_r;
          out_r.granted_slot <= (sts.is_alloc) ? 12'(gslot_r) : '0;
        end
      end
    end
  end

endmodule

// File: hdl/striped_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// striped_slot_allocator_unit: striped slot allocator, top level
// Controller plus datapath; one result per accepted request.
// ----------------------------------------------------------------------------
// One request at a time; in_ready is high only while the block is idle. A free,
// an unknown operation or an allocate on a full segment passes through the
// dispatch, finish and output states. An allocate also walks the section
// rotation and then the hint scan; the scan reads the occupancy memory one slot
// per cycle and takes at most SLOTS/SECTIONS + 1 steps. A reinitialise sweeps
// the occupancy memory one slot per cycle. Right after reset the block runs the
// same sweep with in_ready low before it takes a request. An output stall holds
// the result, and no new request is taken until out_ready is seen.
// first_segment takes effect at the next reinitialise.
module striped_slot_allocator_unit import ssa_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int SECTIONS = SECTIONS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ssa_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ssa_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data
);

  ssa_cmd_t cmd;
  ssa_sts_t sts;
  logic     first_seg_r;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) first_seg_r <= 1'b0;
    else if (cfg_valid) first_seg_r <= cfg_data;
  end

  ssa_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  ssa_dpath #(.SLOTS(SLOTS), .SECTIONS(SECTIONS)) u_dpath (
    .clk, .rst_n, .in_item(in_data), .first_segment(first_seg_r),
    .cmd, .sts, .out_item(out_data)
  );

  // a transfer in is only taken while no result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input ready while result pending");

  // a result is not yet shown right after an accepted item
  a_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");

  // a command never grants and clears in the same cycle
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.grant && cmd.clr_step)) else $error("conflicting commands");

endmodule
